// ===== sv/bounded_sorted_priority_queue_macros.svh =====
// Assertion macros shared by the checker of the sorted priority queue.
`ifndef BOUNDED_SORTED_PRIORITY_QUEUE_MACROS_SVH
`define BOUNDED_SORTED_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clock and held off during reset.
`define BSPQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and held off during reset.
`define BSPQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/bspq_pkg.sv =====
// Shared types and constants of the sorted priority queue.
`default_nettype none
package bspq_pkg;
   localparam int VALUE_W = 32;
   localparam int SUM_W   = 36;
   localparam int OCC_W   = 5;
   localparam int CSR_W   = 5;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_POP    = 1'b1;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic signed [SUM_W-1:0]   sum_type;

   // Command broadcast to every cell of the row.
   typedef struct packed {
      logic      ins;
      logic      pop;
      value_type x;
   } cell_cmd_type;
endpackage
`default_nettype wire

// ===== sv/bspq_req_if.sv =====
// Request channel: operation kind and value, with valid/ready handshake.
`default_nettype none
interface bspq_req_if
   import bspq_pkg::*;
();
   logic      valid;
   logic      ready;
   logic      kind;
   value_type value;

   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);
endinterface
`default_nettype wire

// ===== sv/bspq_rsp_if.sv =====
// Response channel: pop result and queue summary, with valid/ready handshake.
`default_nettype none
interface bspq_rsp_if
   import bspq_pkg::*;
();
   logic                 valid;
   logic                 ready;
   value_type            popped_value;
   logic                 pop_error;
   value_type            largest_entry;
   value_type            smallest_entry;
   sum_type              sum_of_entries;
   logic [OCC_W-1:0]     occupancy;

   modport source (output valid, output popped_value, output pop_error,
                   output largest_entry, output smallest_entry,
                   output sum_of_entries, output occupancy, input ready);
   modport sink   (input valid, input popped_value, input pop_error,
                   input largest_entry, input smallest_entry,
                   input sum_of_entries, input occupancy, output ready);
endinterface
`default_nettype wire

// ===== sv/bspq_cell.sv =====
// One slot of the sorted row: holds an entry and trades it with its neighbors.
`default_nettype none
module bspq_cell
   import bspq_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int CNT_W = 5
) (
   input  wire logic             clock,
   input  wire cell_cmd_type     cmd,
   input  wire logic [CNT_W-1:0] ins_pos_limit,
   input  wire logic [CNT_W-1:0] count,
   input  wire logic             left_ge,
   input  wire value_type        left_entry,
   input  wire value_type        right_entry,
   output logic                  ge,
   output logic                  is_tail,
   output value_type             entry
);
   value_type entry_ff;
   value_type entry_in;
   logic      below_limit;
   logic      at_or_below_limit;
   logic      shift_up;

   always_comb begin
      below_limit       = CNT_W'(INDEX) < ins_pos_limit;
      at_or_below_limit = CNT_W'(INDEX) <= ins_pos_limit;
      shift_up          = CNT_W'(INDEX + 1) < count;
      // This slot keeps its entry when it lies below the insert limit and is not smaller than the new value.
      ge      = below_limit && (entry_ff >= cmd.x);
      is_tail = count == CNT_W'(INDEX + 1);

      entry_in = entry_ff;
      if (cmd.ins && at_or_below_limit) begin
         if (ge) begin
            entry_in = entry_ff;
         end else if (left_ge) begin
            entry_in = cmd.x;
         end else begin
            entry_in = left_entry;
         end
      end else if (cmd.pop && shift_up) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
endmodule
`default_nettype wire

// ===== sv/bounded_sorted_priority_queue.sv =====
// Top level of the bounded sorted priority queue.
// Usage:
//   req_chan carries one operation per transfer: kind 0 inserts value, kind 1
//   pops the largest entry. rsp_chan returns exactly one result per request,
//   in order: the popped value (or an error flag on an empty queue) and the
//   largest, smallest, sum and count of the entries left after the operation.
//   csr_we/csr_wdata set the capacity in use; write it only while idle.
//   Entries live in a row of CAPACITY cells, kept in descending order. Every
//   request is resolved by all cells together, each comparing its entry
//   with the new value and taking its own, its neighbor's or the new value.
//   The cell row takes one request per cycle unless a stalled result holds it.
//   A request is resolved in the cells first; its summary is then built
//   into the output register, which drives rsp_chan.valid.
//   Throughput is one transfer per cycle while the receiver keeps up.
//   When the receiver stalls, one finished result waits in the output
//   register and one more in the cells; req_chan.ready then drops.
//   Reset empties the queue, clears both handshakes and sets the capacity
//   to CAPACITY. Cell contents are not cleared; the count masks them.
`default_nettype none
module bounded_sorted_priority_queue
   import bspq_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   bspq_req_if.sink        req_chan,
   bspq_rsp_if.source      rsp_chan,
   input  wire logic       csr_we,
   input  wire logic [CSR_W-1:0] csr_wdata
);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CAP_W = (CNT_W > CSR_W) ? CNT_W : CSR_W;

   // Capacity register and limit actually applied.
   logic [CAP_W-1:0] cap_ff;
   logic [CAP_W-1:0] cap_in;
   logic [CAP_W-1:0] limit;

   // Queue bookkeeping.
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   sum_type          sum_ff;
   sum_type          sum_in;

   // A request resolved in the cells whose result is not yet in the output register.
   logic             busy_ff;
   logic             busy_in;
   value_type        pend_popped_ff;
   value_type        pend_popped_in;
   logic             pend_err_ff;
   logic             pend_err_in;

   // Output register.
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   value_type        rsp_popped_ff;
   logic             rsp_err_ff;
   value_type        rsp_largest_ff;
   value_type        rsp_smallest_ff;
   sum_type          rsp_sum_ff;
   logic [OCC_W-1:0] rsp_occ_ff;

   logic             req_fire;
   logic             out_free;
   logic             load_out;
   logic             ins_go;
   logic             pop_go;
   logic             pop_err;
   logic             full;
   logic [CNT_W-1:0] ins_pos_limit;
   cell_cmd_type     cmd;
   value_type        tail_val;
   sum_type          x_ext;
   sum_type          tail_ext;
   sum_type          top_ext;

   value_type        entry   [CAPACITY];
   logic             ge      [CAPACITY];
   logic             is_tail [CAPACITY];

   // The cells hold a resolved request until the output register can take it.
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign load_out       = busy_ff && out_free;
   assign req_chan.ready = !busy_ff || out_free;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      // A zero capacity acts as one; anything above the row length is clipped.
      if (cap_ff == '0) begin
         limit = CAP_W'(1);
      end else if (cap_ff > CAP_W'(CAPACITY)) begin
         limit = CAP_W'(CAPACITY);
      end else begin
         limit = cap_ff;
      end
      full = CAP_W'(count_ff) >= limit;

      ins_go  = req_fire && (req_chan.kind == KIND_INSERT);
      pop_go  = req_fire && (req_chan.kind == KIND_POP) && (count_ff != '0);
      pop_err = req_fire && (req_chan.kind == KIND_POP) && (count_ff == '0);

      // On a full queue the tail slot is dropped, so the insert may land on it.
      ins_pos_limit = full ? (count_ff - CNT_W'(1)) : count_ff;

      cmd.ins = ins_go;
      cmd.pop = pop_go;
      cmd.x   = req_chan.value;
   end

   // The tail entry is picked by the one-hot tail flags of the cells.
   always_comb begin
      tail_val = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         tail_val = tail_val | (is_tail[i] ? entry[i] : value_type'(0));
      end
   end

   always_comb begin
      x_ext    = {{(SUM_W - VALUE_W){req_chan.value[VALUE_W-1]}}, req_chan.value};
      tail_ext = {{(SUM_W - VALUE_W){tail_val[VALUE_W-1]}}, tail_val};
      top_ext  = {{(SUM_W - VALUE_W){entry[0][VALUE_W-1]}}, entry[0]};

      count_in = count_ff;
      sum_in   = sum_ff;
      if (ins_go) begin
         if (full) begin
            sum_in = sum_ff + x_ext - tail_ext;
         end else begin
            sum_in   = sum_ff + x_ext;
            count_in = count_ff + CNT_W'(1);
         end
      end else if (pop_go) begin
         sum_in   = sum_ff - top_ext;
         count_in = count_ff - CNT_W'(1);
      end

      pend_popped_in = pend_popped_ff;
      pend_err_in    = pend_err_ff;
      if (req_fire) begin
         pend_popped_in = pop_go ? entry[0] : value_type'(0);
         pend_err_in    = pop_err;
      end

      if (req_fire) begin
         busy_in = 1'b1;
      end else if (load_out) begin
         busy_in = 1'b0;
      end else begin
         busy_in = busy_ff;
      end

      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      cap_in = csr_we ? CAP_W'(csr_wdata) : cap_ff;
   end

   // Row of cells, each trading entries with its neighbors.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic      left_ge_w;
      value_type left_entry_w;
      value_type right_entry_w;

      if (g == 0) begin : g_first
         assign left_ge_w    = 1'b1;
         assign left_entry_w = '0;
      end else begin : g_inner_left
         assign left_ge_w    = ge[g-1];
         assign left_entry_w = entry[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign right_entry_w = '0;
      end else begin : g_inner_right
         assign right_entry_w = entry[g+1];
      end

      bspq_cell #(
         .INDEX (g),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock         (clock),
         .cmd           (cmd),
         .ins_pos_limit (ins_pos_limit),
         .count         (count_ff),
         .left_ge       (left_ge_w),
         .left_entry    (left_entry_w),
         .right_entry   (right_entry_w),
         .ge            (ge[g]),
         .is_tail       (is_tail[g]),
         .entry         (entry[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_W'(CAPACITY);
         count_ff     <= '0;
         sum_ff       <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers; the summary is read from the settled cells.
   always_ff @(posedge clock) begin
      pend_popped_ff <= pend_popped_in;
      pend_err_ff    <= pend_err_in;
      if (load_out) begin
         rsp_popped_ff   <= pend_popped_ff;
         rsp_err_ff      <= pend_err_ff;
         rsp_largest_ff  <= (count_ff != '0) ? entry[0] : value_type'(0);
         rsp_smallest_ff <= (count_ff != '0) ? tail_val : value_type'(0);
         rsp_sum_ff      <= sum_ff;
         rsp_occ_ff      <= OCC_W'(count_ff);
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.popped_value   = rsp_popped_ff;
   assign rsp_chan.pop_error      = rsp_err_ff;
   assign rsp_chan.largest_entry  = rsp_largest_ff;
   assign rsp_chan.smallest_entry = rsp_smallest_ff;
   assign rsp_chan.sum_of_entries = rsp_sum_ff;
   assign rsp_chan.occupancy      = rsp_occ_ff;
endmodule
`default_nettype wire

// ===== sv/bspq_checker.sv =====
// Port-level checker of the sorted priority queue, bound to the top level.
`default_nettype none
`include "bounded_sorted_priority_queue_macros.svh"
module bspq_checker
   import bspq_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire value_type        rsp_popped_value,
   input wire logic             rsp_pop_error,
   input wire value_type        rsp_largest_entry,
   input wire value_type        rsp_smallest_entry,
   input wire sum_type          rsp_sum_of_entries,
   input wire logic [OCC_W-1:0] rsp_occupancy
);
   // A stalled result must stay put until it is taken.
   `BSPQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_popped_value) && $stable(rsp_sum_of_entries) && $stable(rsp_occupancy), "stalled response changed")

   // A failed pop returns nothing.
   `BSPQ_ASSERT_NOW(a_err_no_value, rsp_valid && rsp_pop_error, rsp_popped_value == '0, "pop error with a value")

   // A failed pop only happens on an empty queue, which reports all zeros.
   `BSPQ_ASSERT_NOW(a_err_empty, rsp_valid && rsp_pop_error, (rsp_occupancy == '0) && (rsp_largest_entry == '0) && (rsp_smallest_entry == '0) && (rsp_sum_of_entries == '0), "pop error on non-empty queue")

   // The head of a non-empty queue is never below its tail.
   `BSPQ_ASSERT_NOW(a_order, rsp_valid && (rsp_occupancy != '0), rsp_largest_entry >= rsp_smallest_entry, "queue order broken")
endmodule

bind bounded_sorted_priority_queue bspq_checker u_bspq_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_popped_value   (rsp_chan.popped_value),
   .rsp_pop_error      (rsp_chan.pop_error),
   .rsp_largest_entry  (rsp_chan.largest_entry),
   .rsp_smallest_entry (rsp_chan.smallest_entry),
   .rsp_sum_of_entries (rsp_chan.sum_of_entries),
   .rsp_occupancy      (rsp_chan.occupancy)
);
`default_nettype wire
